@@ rtl/core/contour_distance_peak_detector_defines.svh @@
// Assertion macros used by the cdpd_track module of the contour distance peak detector
`ifndef CONTOUR_DISTANCE_PEAK_DETECTOR_DEFINES_SVH
`define CONTOUR_DISTANCE_PEAK_DETECTOR_DEFINES_SVH

// same-cycle implication, idle while reset is asserted
`define CDPD_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, idle while reset is asserted
`define CDPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/cdpd_pkg.sv @@
// Shared constants and types of the contour distance peak detector
package cdpd_pkg;

    localparam int MAX_TIPS_DEFAULT    = 6;
    localparam int COORD_WIDTH_DEFAULT = 12;
    localparam int COUNT_W             = 3;
    localparam int BOTTOM_MARGIN       = 10;
    localparam int FRAME_HEIGHT_RESET  = 480;
    localparam int CFG_INDEX_W         = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CENTER_X     = 2'd0,
        CFG_CENTER_Y     = 2'd1,
        CFG_FRAME_HEIGHT = 2'd2
    } t_cfg_index;

    localparam logic KIND_TIP   = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    typedef struct packed {
        logic first;
        logic second;
    } t_push;

endpackage

@@ rtl/core/contour_distance_peak_detector.sv @@
// Top level of the contour distance peak detector
//
//  port group    dir  role
//  i_cfg_*       in   register writes: centre x, centre y, frame height
//  s_axis_*      in   contour points, tlast marks the final point
//  m_axis_*      out  fingertip and count reports, tuser gives the kind
//
//  Accepts one point per cycle while s_axis_tready is high; the first result of a
//  point passes the input register, the distance register and the result queue
//  before it is valid at the output.
//  A point that yields a tip and a count gives two reports, the tip report first.
//  Synchronous active-low reset empties the pipeline, clears contour state and
//  loads register defaults (frame height 480).
//  m_axis_tready low holds the output; input stalls once both stages are full
//  and the queue holds two or more results.
module contour_distance_peak_detector #(
    parameter int MAX_TIPS    = cdpd_pkg::MAX_TIPS_DEFAULT,
    parameter int COORD_WIDTH = cdpd_pkg::COORD_WIDTH_DEFAULT,
    localparam int IN_W       = ((2 * COORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_W      = ((2 * COORD_WIDTH + cdpd_pkg::COUNT_W + 7) / 8) * 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [cdpd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [COORD_WIDTH-1:0]           i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [IN_W-1:0]                  s_axis_tdata,  // point_x, point_y
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [OUT_W-1:0]                 m_axis_tdata,  // tip_x, tip_y, finger_count
    output logic                             m_axis_tuser,  // kind
    output logic                             m_axis_tlast
);

    localparam int DIST_W = 2 * COORD_WIDTH + 1;
    localparam int RES_W  = 2 * COORD_WIDTH + cdpd_pkg::COUNT_W + 2;

    logic [COORD_WIDTH-1:0] r_center_x;
    logic [COORD_WIDTH-1:0] r_center_y;
    logic [COORD_WIDTH-1:0] r_frame_height;

    logic                          w_d_valid;
    logic                          w_d_ready;
    logic [DIST_W-1:0]             w_d_dist;
    logic [COORD_WIDTH-1:0]        w_d_x;
    logic [COORD_WIDTH-1:0]        w_d_y;
    logic                          w_d_last;
    logic                          w_room;
    cdpd_pkg::t_push               w_push;
    logic [RES_W-1:0]              w_res_first;
    logic [RES_W-1:0]              w_res_second;
    logic [RES_W-1:0]              w_head;
    logic                          w_kind;
    logic [COORD_WIDTH-1:0]        w_tip_x;
    logic [COORD_WIDTH-1:0]        w_tip_y;
    logic [cdpd_pkg::COUNT_W-1:0]  w_count;
    logic                          w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x     <= '0;
            r_center_y     <= '0;
            r_frame_height <= COORD_WIDTH'(cdpd_pkg::FRAME_HEIGHT_RESET);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                cdpd_pkg::CFG_CENTER_X:     r_center_x     <= i_cfg_data;
                cdpd_pkg::CFG_CENTER_Y:     r_center_y     <= i_cfg_data;
                cdpd_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    cdpd_dist #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_x        (s_axis_tdata[COORD_WIDTH-1:0]),
        .i_y        (s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .i_last     (s_axis_tlast),
        .o_valid    (w_d_valid),
        .i_ready    (w_d_ready),
        .o_dist     (w_d_dist),
        .o_x        (w_d_x),
        .o_y        (w_d_y),
        .o_last     (w_d_last)
    );

    cdpd_track #(
        .MAX_TIPS   (MAX_TIPS),
        .COORD_WIDTH(COORD_WIDTH)
    ) u_track (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_height (r_frame_height),
        .i_valid        (w_d_valid),
        .o_ready        (w_d_ready),
        .i_dist         (w_d_dist),
        .i_x            (w_d_x),
        .i_y            (w_d_y),
        .i_last         (w_d_last),
        .i_room         (w_room),
        .o_push         (w_push),
        .o_res_first    (w_res_first),
        .o_res_second   (w_res_second)
    );

    cdpd_out_queue #(
        .RES_W(RES_W)
    ) u_out_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_res_first  (w_res_first),
        .i_res_second (w_res_second),
        .o_room       (w_room),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_res        (w_head)
    );

    assign {w_kind, w_tip_x, w_tip_y, w_count, w_last} = w_head;

    assign m_axis_tdata = OUT_W'({w_count, w_tip_y, w_tip_x});
    assign m_axis_tuser = w_kind;
    assign m_axis_tlast = w_last;

endmodule

@@ rtl/core/cdpd_dist.sv @@
// Input register and squared-distance stage
module cdpd_dist #(
    parameter int COORD_WIDTH = cdpd_pkg::COORD_WIDTH_DEFAULT,
    localparam int DIST_W     = 2 * COORD_WIDTH + 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [COORD_WIDTH-1:0] i_center_x,
    input  logic [COORD_WIDTH-1:0] i_center_y,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [COORD_WIDTH-1:0] i_x,
    input  logic [COORD_WIDTH-1:0] i_y,
    input  logic                   i_last,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [DIST_W-1:0]      o_dist,
    output logic [COORD_WIDTH-1:0] o_x,
    output logic [COORD_WIDTH-1:0] o_y,
    output logic                   o_last
);

    logic                   r_s1_valid;
    logic [COORD_WIDTH-1:0] r_s1_x;
    logic [COORD_WIDTH-1:0] r_s1_y;
    logic                   r_s1_last;
    logic                   r_s2_valid;
    logic [DIST_W-1:0]      r_s2_dist;
    logic [COORD_WIDTH-1:0] r_s2_x;
    logic [COORD_WIDTH-1:0] r_s2_y;
    logic                   r_s2_last;

    logic                     w_s2_adv;
    logic                     w_s1_adv;
    logic [COORD_WIDTH-1:0]   w_dx;
    logic [COORD_WIDTH-1:0]   w_dy;
    logic [2*COORD_WIDTH-1:0] w_sqx;
    logic [2*COORD_WIDTH-1:0] w_sqy;
    logic [DIST_W-1:0]        n_dist;

    assign w_s2_adv = !r_s2_valid || i_ready;
    assign w_s1_adv = !r_s1_valid || w_s2_adv;
    assign o_ready  = w_s1_adv;

    assign w_dx   = (i_center_x > r_s1_x) ? (i_center_x - r_s1_x) : (r_s1_x - i_center_x);
    assign w_dy   = (i_center_y > r_s1_y) ? (i_center_y - r_s1_y) : (r_s1_y - i_center_y);
    assign w_sqx  = {{COORD_WIDTH{1'b0}}, w_dx} * {{COORD_WIDTH{1'b0}}, w_dx};
    assign w_sqy  = {{COORD_WIDTH{1'b0}}, w_dy} * {{COORD_WIDTH{1'b0}}, w_dy};
    assign n_dist = {1'b0, w_sqx} + {1'b0, w_sqy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_s1_adv) begin
                r_s1_valid <= i_valid;
            end
            if (w_s2_adv) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && i_valid) begin
            r_s1_x    <= i_x;
            r_s1_y    <= i_y;
            r_s1_last <= i_last;
        end
        if (w_s2_adv && r_s1_valid) begin
            r_s2_dist <= n_dist;
            r_s2_x    <= r_s1_x;
            r_s2_y    <= r_s1_y;
            r_s2_last <= r_s1_last;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_dist  = r_s2_dist;
    assign o_x     = r_s2_x;
    assign o_y     = r_s2_y;
    assign o_last  = r_s2_last;

endmodule

@@ rtl/core/cdpd_track.sv @@
// Contour state, local-maximum test and result formation
`include "contour_distance_peak_detector_defines.svh"

module cdpd_track #(
    parameter int MAX_TIPS    = cdpd_pkg::MAX_TIPS_DEFAULT,
    parameter int COORD_WIDTH = cdpd_pkg::COORD_WIDTH_DEFAULT,
    localparam int DIST_W     = 2 * COORD_WIDTH + 1,
    localparam int TIPS_W     = $clog2(MAX_TIPS + 1),
    localparam int RES_W      = 2 * COORD_WIDTH + cdpd_pkg::COUNT_W + 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [COORD_WIDTH-1:0] i_frame_height,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [DIST_W-1:0]      i_dist,
    input  logic [COORD_WIDTH-1:0] i_x,
    input  logic [COORD_WIDTH-1:0] i_y,
    input  logic                   i_last,
    input  logic                   i_room,
    output cdpd_pkg::t_push        o_push,
    output logic [RES_W-1:0]       o_res_first,
    output logic [RES_W-1:0]       o_res_second
);

    logic [DIST_W-1:0]      r_prev;
    logic [DIST_W-1:0]      r_older;
    logic [COORD_WIDTH-1:0] r_cand_x;
    logic [COORD_WIDTH-1:0] r_cand_y;
    logic [TIPS_W-1:0]      r_tips;
    logic                   r_done;

    logic                   w_fire;
    logic                   w_y_ok;
    logic                   w_hit;
    logic [TIPS_W-1:0]      w_tips_inc;
    logic [TIPS_W-1:0]      w_tips_after;
    logic [RES_W-1:0]       w_tip_res;
    logic [RES_W-1:0]       w_count_res;

    assign w_fire  = i_valid && i_room;
    assign o_ready = i_room;

    assign w_y_ok = ({1'b0, r_cand_y} + (COORD_WIDTH + 1)'(cdpd_pkg::BOTTOM_MARGIN))
                    < {1'b0, i_frame_height};
    assign w_hit  = !r_done && (i_dist < r_prev) && (r_prev > r_older)
                    && (r_cand_x != '0) && w_y_ok;

    assign w_tips_inc   = r_tips + TIPS_W'(1);
    assign w_tips_after = w_hit ? w_tips_inc : r_tips;

    assign w_tip_res   = {cdpd_pkg::KIND_TIP, r_cand_x, r_cand_y,
                          cdpd_pkg::COUNT_W'(w_tips_inc), !i_last};
    assign w_count_res = {cdpd_pkg::KIND_COUNT, {COORD_WIDTH{1'b0}}, {COORD_WIDTH{1'b0}},
                          cdpd_pkg::COUNT_W'(w_tips_after), 1'b1};

    assign o_res_first   = w_hit ? w_tip_res : w_count_res;
    assign o_res_second  = w_count_res;
    assign o_push.first  = w_fire && (w_hit || i_last);
    assign o_push.second = w_fire && w_hit && i_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_older  <= '0;
            r_cand_x <= '0;
            r_cand_y <= '0;
            r_tips   <= '0;
            r_done   <= 1'b0;
        end else if (w_fire) begin
            if (i_last) begin
                r_prev   <= '0;
                r_older  <= '0;
                r_cand_x <= '0;
                r_cand_y <= '0;
                r_tips   <= '0;
                r_done   <= 1'b0;
            end else if (!r_done) begin
                r_older  <= r_prev;
                r_prev   <= i_dist;
                r_cand_x <= i_x;
                r_cand_y <= i_y;
                r_tips   <= w_tips_after;
                r_done   <= w_hit && (w_tips_inc >= TIPS_W'(MAX_TIPS));
            end
        end
    end

    `CDPD_ASSERT(a_done_at_limit, i_clk, i_rst_n, r_done, r_tips == TIPS_W'(MAX_TIPS), "search stopped below the tip limit")
    `CDPD_ASSERT(a_tips_bounded, i_clk, i_rst_n, 1'b1, r_tips <= TIPS_W'(MAX_TIPS), "tip count beyond limit")
    `CDPD_ASSERT(a_second_needs_first, i_clk, i_rst_n, o_push.second, o_push.first && w_hit && i_last, "second result without tip and end mark")
    `CDPD_ASSERT_NEXT(a_clear_on_end, i_clk, i_rst_n, w_fire && i_last, r_tips == '0 && !r_done && r_prev == '0, "contour state not cleared after end mark")

endmodule

@@ rtl/core/cdpd_out_queue.sv @@
// Three-entry result queue feeding the output stream
module cdpd_out_queue #(
    parameter int RES_W = 2 * cdpd_pkg::COORD_WIDTH_DEFAULT + cdpd_pkg::COUNT_W + 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cdpd_pkg::t_push  i_push,
    input  logic [RES_W-1:0] i_res_first,
    input  logic [RES_W-1:0] i_res_second,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [RES_W-1:0] o_res
);

    localparam int DEPTH = 3;

    logic [RES_W-1:0] r_entry [DEPTH];
    logic [1:0]       r_wr;
    logic [1:0]       r_rd;
    logic [1:0]       r_count;

    logic       w_pop;
    logic [1:0] w_wr_next;
    logic [1:0] n_wr;
    logic [1:0] n_rd;
    logic [1:0] n_count;

    function automatic logic [1:0] ptr_inc(input logic [1:0] ptr);
        ptr_inc = (ptr == 2'(DEPTH - 1)) ? 2'd0 : ptr + 2'd1;
    endfunction

    assign w_pop     = o_valid && i_ready;
    assign w_wr_next = ptr_inc(r_wr);

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push.second) begin
            n_wr = ptr_inc(w_wr_next);
        end else if (i_push.first) begin
            n_wr = w_wr_next;
        end
        if (w_pop) begin
            n_rd = ptr_inc(r_rd);
        end
        n_count = r_count + {1'b0, i_push.first} + {1'b0, i_push.second} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (i_push.first && r_wr == 2'(i)) begin
                r_entry[i] <= i_res_first;
            end else if (i_push.second && w_wr_next == 2'(i)) begin
                r_entry[i] <= i_res_second;
            end
        end
    end

    assign o_room  = r_count <= 2'd1;
    assign o_valid = r_count != 2'd0;
    assign o_res   = r_entry[r_rd];

endmodule

@@ bench/testbench.sv @@
// Testbench for the contour distance peak detector: directed and random contours
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_POINTS = 130;
    localparam int NUM_PHASES   = 10;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        logic        kind;
        logic [11:0] x;
        logic [11:0] y;
        logic [2:0]  count;
        logic        last;
    } t_report;

    class fingertip_tracker;
        logic [11:0] centre_x;
        logic [11:0] centre_y;
        logic [11:0] frame_h;
        logic [25:0] dist_prev;
        logic [25:0] dist_older;
        logic [11:0] cand_x;
        logic [11:0] cand_y;
        int          tips;
        bit          search_over;
        t_report     awaited_reports[$];
        int          errors;
        int          tips_seen;
        int          counts_seen;

        function new();
            centre_x    = '0;
            centre_y    = '0;
            frame_h     = 12'(cdpd_pkg::FRAME_HEIGHT_RESET);
            errors      = 0;
            tips_seen   = 0;
            counts_seen = 0;
            clear_contour();
        endfunction

        function void clear_contour();
            dist_prev   = '0;
            dist_older  = '0;
            cand_x      = '0;
            cand_y      = '0;
            tips        = 0;
            search_over = 1'b0;
        endfunction

        function void set_reg(cdpd_pkg::t_cfg_index idx, logic [11:0] val);
            case (idx)
                cdpd_pkg::CFG_CENTER_X:     centre_x = val;
                cdpd_pkg::CFG_CENTER_Y:     centre_y = val;
                cdpd_pkg::CFG_FRAME_HEIGHT: frame_h  = val;
                default: ;
            endcase
        endfunction

        function void note_point(logic [11:0] px, logic [11:0] py, logic eoc);
            logic [11:0] dx;
            logic [11:0] dy;
            logic [25:0] dist_now;
            int          before_n;
            before_n = awaited_reports.size();
            if (!search_over) begin
                dx       = (centre_x > px) ? centre_x - px : px - centre_x;
                dy       = (centre_y > py) ? centre_y - py : py - centre_y;
                dist_now = 26'(dx) * 26'(dx) + 26'(dy) * 26'(dy);
                if (dist_now < dist_prev && dist_prev > dist_older && cand_x != 0 &&
                    int'(cand_y) < int'(frame_h) - cdpd_pkg::BOTTOM_MARGIN) begin
                    tips++;
                    awaited_reports.push_back('{cdpd_pkg::KIND_TIP, cand_x, cand_y,
                                                3'(tips), 1'b0});
                    if (tips >= cdpd_pkg::MAX_TIPS_DEFAULT)
                        search_over = 1'b1;
                end
                dist_older = dist_prev;
                dist_prev  = dist_now;
                cand_x     = px;
                cand_y     = py;
            end
            if (eoc) begin
                awaited_reports.push_back('{cdpd_pkg::KIND_COUNT, 12'd0, 12'd0,
                                            3'(tips), 1'b0});
                clear_contour();
            end
            if (awaited_reports.size() > before_n)
                awaited_reports[$].last = 1'b1;
        endfunction

        function void check_report(t_report got);
            t_report exp;
            bit      bad;
            if (awaited_reports.size() == 0) begin
                $display("%0t: unexpected report kind %0d x %0d y %0d count %0d last %0d",
                         $time, got.kind, got.x, got.y, got.count, got.last);
                errors++;
                return;
            end
            exp = awaited_reports.pop_front();
            bad = 1'b0;
            if (got.kind !== exp.kind) begin
                $display("%0t: kind expected %0d got %0d", $time, exp.kind, got.kind);
                bad = 1'b1;
            end
            if (got.x !== exp.x) begin
                $display("%0t: tip_x expected %0d got %0d", $time, exp.x, got.x);
                bad = 1'b1;
            end
            if (got.y !== exp.y) begin
                $display("%0t: tip_y expected %0d got %0d", $time, exp.y, got.y);
                bad = 1'b1;
            end
            if (got.count !== exp.count) begin
                $display("%0t: finger_count expected %0d got %0d", $time, exp.count, got.count);
                bad = 1'b1;
            end
            if (got.last !== exp.last) begin
                $display("%0t: tlast expected %0d got %0d", $time, exp.last, got.last);
                bad = 1'b1;
            end
            if (bad)
                errors++;
            if (exp.kind == cdpd_pkg::KIND_TIP)
                tips_seen++;
            else
                counts_seen++;
        endfunction
    endclass

    logic                             i_clk         = 1'b0;
    logic                             i_rst_n       = 1'b0;
    logic                             i_cfg_wr_en   = 1'b0;
    logic [cdpd_pkg::CFG_INDEX_W-1:0] i_cfg_index   = cdpd_pkg::CFG_CENTER_X;
    logic [11:0]                      i_cfg_data    = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [23:0]                      s_axis_tdata  = '0;
    logic                             s_axis_tlast  = 1'b0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [31:0]                      m_axis_tdata;
    logic                             m_axis_tuser;
    logic                             m_axis_tlast;

    fingertip_tracker tracker;
    bit               idle_on    = 1'b0;
    int               stall_left = 0;
    int               cycles     = 0;
    int               points_sent = 0;
    int               contours_sent = 0;

    contour_distance_peak_detector u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d reports outstanding", $time,
                     tracker.awaited_reports.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // stall the report side in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_report('{m_axis_tuser, m_axis_tdata[11:0], m_axis_tdata[23:12],
                                   m_axis_tdata[26:24], m_axis_tlast});
    end

    task automatic send_point(input logic [11:0] px, input logic [11:0] py, input logic eoc);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {py, px};
        s_axis_tlast  <= eoc;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        tracker.note_point(px, py, eoc);
        points_sent++;
        if (eoc)
            contours_sent++;
    endtask

    // drain every report and the pipeline behind it
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (tracker.awaited_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [11:0] cx, input logic [11:0] cy,
                              input logic [11:0] fh);
        settle();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= cdpd_pkg::CFG_CENTER_X;
        i_cfg_data  <= cx;
        @(posedge i_clk);
        i_cfg_index <= cdpd_pkg::CFG_CENTER_Y;
        i_cfg_data  <= cy;
        @(posedge i_clk);
        i_cfg_index <= cdpd_pkg::CFG_FRAME_HEIGHT;
        i_cfg_data  <= fh;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        tracker.set_reg(cdpd_pkg::CFG_CENTER_X, cx);
        tracker.set_reg(cdpd_pkg::CFG_CENTER_Y, cy);
        tracker.set_reg(cdpd_pkg::CFG_FRAME_HEIGHT, fh);
    endtask

    function automatic logic [11:0] near(input logic [11:0] c);
        int v;
        v = int'(c) + int'($urandom_range(0, 600)) - 300;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return 12'(v);
    endfunction

    task automatic random_contour(input int len);
        logic [11:0] px;
        logic [11:0] py;
        logic [11:0] lx;
        logic [11:0] ly;
        int          sel;
        lx = '0;
        ly = '0;
        for (int k = 0; k < len; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                px = near(tracker.centre_x);
                py = near(tracker.centre_y);
            end else if (sel < 70) begin
                px = '0;
                py = near(tracker.centre_y);
            end else if (sel < 80) begin
                px = near(tracker.centre_x);
                py = 12'(int'(tracker.frame_h) - 12 + int'($urandom_range(0, 4)));
            end else if (sel < 88 && k > 0) begin
                px = lx;
                py = ly;
            end else begin
                px = 12'($urandom);
                py = 12'($urandom);
            end
            send_point(px, py, k == len - 1);
            lx = px;
            ly = py;
        end
    endtask

    initial begin
        int          phase_start;
        logic [11:0] cfg_x[8];
        logic [11:0] cfg_y[8];
        logic [11:0] cfg_h[8];
        cfg_x = '{12'd2048, 12'd4095, 12'd100, 12'd2000, 12'd1500, 12'd0, 12'd4095, 12'd0};
        cfg_y = '{12'd2048, 12'd4095, 12'd3000, 12'd100, 12'd1500, 12'd4095, 12'd0, 12'd0};
        cfg_h = '{12'd4095, 12'd4095, 12'd9, 12'd10, 12'd11, 12'd0, 12'd2000, 12'd480};
        tracker = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part under the reset settings: centre at origin, height 480
        send_point(12'd77, 12'd33, 1'b1);
        send_point(12'd100, 12'd100, 1'b0);
        send_point(12'd200, 12'd200, 1'b0);
        send_point(12'd50, 12'd50, 1'b1);
        send_point(12'd10, 12'd10, 1'b0);
        send_point(12'd0, 12'd300, 1'b0);
        send_point(12'd5, 12'd5, 1'b0);
        send_point(12'd300, 12'd469, 1'b0);
        send_point(12'd5, 12'd5, 1'b0);
        send_point(12'd300, 12'd470, 1'b0);
        send_point(12'd5, 12'd5, 1'b1);
        send_point(12'd4095, 12'd4095, 1'b0);
        send_point(12'd0, 12'd0, 1'b1);
        // alternate near and far until the search is exhausted
        for (int k = 0; k < 15; k++) begin
            if (k % 2 == 1)
                send_point(12'(400 + k), 12'd300, 1'b0);
            else
                send_point(12'd5, 12'd5, k == 14);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < 8)
                set_config(cfg_x[p], cfg_y[p], cfg_h[p]);
            else
                set_config(12'($urandom), 12'($urandom), 12'($urandom_range(0, 4095)));
            idle_on = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            phase_start = points_sent;
            while (points_sent - phase_start < PHASE_POINTS) begin
                if ($urandom_range(0, 4) == 0)
                    random_contour($urandom_range(13, 40));
                else
                    random_contour($urandom_range(1, 12));
            end
        end

        settle();
        $display("Sent %0d points in %0d contours over %0d register settings",
                 points_sent, contours_sent, NUM_PHASES + 1);
        $display("Checked %0d fingertip and %0d count reports, %0d with errors",
                 tracker.tips_seen, tracker.counts_seen, tracker.errors);
        if (tracker.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/cdpd_pkg.sv
rtl/core/cdpd_dist.sv
rtl/core/cdpd_track.sv
rtl/core/cdpd_out_queue.sv
rtl/core/contour_distance_peak_detector.sv
bench/testbench.sv
